// ===== hdl/skt_pkg.sv =====
// shared types, codes and command/status structs for the sorted key table
package skt_pkg;

  typedef logic [1:0]  req_t;
  typedef logic [16:0] key_t;
  typedef logic [31:0] tag_t;
  typedef logic [2:0]  status_t;

  localparam req_t REQ_INSERT = 2'd0;
  localparam req_t REQ_DELETE = 2'd1;
  localparam req_t REQ_CLEAR  = 2'd2;
  localparam req_t REQ_READ   = 2'd3;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_RANGE    = 3'd2;
  localparam status_t ST_NOTFOUND = 3'd3;
  localparam status_t ST_EMPTY    = 3'd4;

  localparam key_t MAX_KEY_RESET = 17'd99999;

  // index register operations
  localparam logic [2:0] P_HOLD = 3'd0;
  localparam logic [2:0] P_ZERO = 3'd1;
  localparam logic [2:0] P_TOP  = 3'd2;
  localparam logic [2:0] P_INC  = 3'd3;
  localparam logic [2:0] P_DEC  = 3'd4;

  // write address selects
  localparam logic [1:0] WA_ZERO = 2'd0;
  localparam logic [1:0] WA_NEXT = 2'd1;
  localparam logic [1:0] WA_PREV = 2'd2;

  // entry count operations
  localparam logic [1:0] CNT_HOLD  = 2'd0;
  localparam logic [1:0] CNT_INC   = 2'd1;
  localparam logic [1:0] CNT_DEC   = 2'd2;
  localparam logic [1:0] CNT_CLEAR = 2'd3;

  typedef struct packed {
    key_t key;
    tag_t tag;
  } entry_t;

  typedef struct packed {
    logic       accept;
    logic       capture;
    logic [2:0] p_op;
    logic       rd_en;
    logic       wr_en;
    logic [1:0] wr_addr_sel;
    logic       wr_new;
    logic [1:0] cnt_op;
    logic       out_load;
    status_t    out_status;
    logic       out_entry;
    logic       out_last;
  } skt_cmd_t;

  typedef struct packed {
    logic in_valid;
    req_t req_type;
    logic full;
    logic empty;
    logic key_gt_max;
    logic rd_gt;
    logic rd_eq;
    logic p_zero;
    logic p_last;
    logic out_free;
  } skt_stat_t;

endpackage

// ===== hdl/skt_ifs.sv =====
// valid/ready channel interfaces for requests, results and configuration
interface skt_in_if;
  logic             valid;
  logic             ready;
  skt_pkg::req_t    req_type;
  skt_pkg::key_t    key;
  skt_pkg::tag_t    payload_tag;

  modport source (output valid, output req_type, output key, output payload_tag,
                  input ready);
  modport sink   (input valid, input req_type, input key, input payload_tag,
                  output ready);
endinterface

interface skt_out_if;
  logic             valid;
  logic             ready;
  skt_pkg::status_t status;
  skt_pkg::key_t    key_out;
  skt_pkg::tag_t    tag_out;
  logic             last;

  modport source (output valid, output status, output key_out, output tag_out,
                  output last, input ready);
  modport sink   (input valid, input status, input key_out, input tag_out,
                  input last, output ready);
endinterface

interface skt_cfg_if;
  logic          valid;
  logic          ready;
  skt_pkg::key_t max_key;

  modport source (output valid, output max_key, input ready);
  modport sink   (input valid, input max_key, output ready);
endinterface

// ===== hdl/skt_dp.sv =====
// datapath: entry memory, index and count registers, limit register, result register
module skt_dp #(
  parameter int CAPACITY = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  skt_in_if.sink            in_if,
  skt_out_if.source         out_if,
  skt_cfg_if.sink           cfg_if,
  input  skt_pkg::skt_cmd_t cmd,
  output skt_pkg::skt_stat_t stat
);
  import skt_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  entry_t             mem [CAPACITY];
  entry_t             rd_q;
  key_t               key_r;
  tag_t               tag_r;
  key_t               max_key_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   cnt_m1;
  logic [IDX_W-1:0]   p_r, p_nxt;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic               out_valid_r;
  status_t            status_r;
  key_t               key_out_r;
  tag_t               tag_out_r;
  logic               last_r;

  assign cnt_m1 = cnt_r - CNT_W'(1);

  always_comb begin
    case (cmd.p_op)
      P_ZERO:  p_nxt = '0;
      P_TOP:   p_nxt = cnt_m1[IDX_W-1:0];
      P_INC:   p_nxt = p_r + IDX_W'(1);
      P_DEC:   p_nxt = p_r - IDX_W'(1);
      default: p_nxt = p_r;
    endcase
  end

  always_comb begin
    case (cmd.wr_addr_sel)
      WA_NEXT: wr_addr = p_r + IDX_W'(1);
      WA_PREV: wr_addr = p_r - IDX_W'(1);
      default: wr_addr = '0;
    endcase
  end

  assign wr_data = cmd.wr_new ? entry_t'{key: key_r, tag: tag_r} : rd_q;

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC:   cnt_nxt = cnt_r + CNT_W'(1);
      CNT_DEC:   cnt_nxt = cnt_m1;
      CNT_CLEAR: cnt_nxt = '0;
      default:   cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[p_nxt];
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    if (cmd.capture) begin
      key_r <= in_if.key;
      tag_r <= in_if.payload_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      max_key_r <= MAX_KEY_RESET;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_if.valid) begin
        max_key_r <= cfg_if.max_key;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_r  <= cmd.out_status;
      key_out_r <= cmd.out_entry ? rd_q.key : '0;
      tag_out_r <= cmd.out_entry ? rd_q.tag : '0;
      last_r    <= cmd.out_last;
    end
  end

  assign in_if.ready    = cmd.accept;
  assign cfg_if.ready   = 1'b1;
  assign out_if.valid   = out_valid_r;
  assign out_if.status  = status_r;
  assign out_if.key_out = key_out_r;
  assign out_if.tag_out = tag_out_r;
  assign out_if.last    = last_r;

  assign stat.in_valid   = in_if.valid;
  assign stat.req_type   = in_if.req_type;
  assign stat.full       = (cnt_r == CNT_W'(CAPACITY));
  assign stat.empty      = (cnt_r == '0);
  assign stat.key_gt_max = (in_if.key > max_key_r);
  assign stat.rd_gt      = (rd_q.key > key_r);
  assign stat.rd_eq      = (rd_q.key == key_r);
  assign stat.p_zero     = (p_r == '0);
  assign stat.p_last     = (CNT_W'(p_r) == cnt_m1);
  assign stat.out_free   = !out_valid_r || out_if.ready;

endmodule

// ===== hdl/skt_ctrl.sv =====
// controller: request sequencing for insert, delete, clear and read-out walks
module skt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  skt_pkg::skt_stat_t stat,
  output skt_pkg::skt_cmd_t  cmd
);
  import skt_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_INS_CMP   = 3'd1;
  localparam logic [2:0] S_INS_PUT   = 3'd2;
  localparam logic [2:0] S_DEL_CMP   = 3'd3;
  localparam logic [2:0] S_DEL_SHIFT = 3'd4;
  localparam logic [2:0] S_RO_EMIT   = 3'd5;
  localparam logic [2:0] S_RESP      = 3'd6;

  logic [2:0] state_r, state_nxt;
  status_t    resp_r, resp_nxt;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    resp_nxt    = resp_r;
    case (state_r)
      S_IDLE: begin
        cmd.accept = 1'b1;
        if (stat.in_valid) begin
          cmd.capture = 1'b1;
          case (stat.req_type)
            REQ_INSERT: begin
              if (stat.full) begin
                resp_nxt  = ST_FULL;
                state_nxt = S_RESP;
              end else if (stat.key_gt_max) begin
                resp_nxt  = ST_RANGE;
                state_nxt = S_RESP;
              end else if (stat.empty) begin
                state_nxt = S_INS_PUT;
              end else begin
                cmd.p_op  = P_TOP;
                cmd.rd_en = 1'b1;
                state_nxt = S_INS_CMP;
              end
            end
            REQ_DELETE: begin
              if (stat.empty) begin
                resp_nxt  = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                cmd.p_op  = P_ZERO;
                cmd.rd_en = 1'b1;
                state_nxt = S_DEL_CMP;
              end
            end
            REQ_CLEAR: begin
              cmd.cnt_op = CNT_CLEAR;
              resp_nxt   = ST_OK;
              state_nxt  = S_RESP;
            end
            default: begin
              if (stat.empty) begin
                resp_nxt  = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                cmd.p_op  = P_ZERO;
                cmd.rd_en = 1'b1;
                state_nxt = S_RO_EMIT;
              end
            end
          endcase
        end
      end
      S_INS_CMP: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_NEXT;
        if (stat.rd_gt) begin
          if (stat.p_zero) begin
            state_nxt = S_INS_PUT;
          end else begin
            cmd.p_op  = P_DEC;
            cmd.rd_en = 1'b1;
          end
        end else begin
          cmd.wr_new = 1'b1;
          cmd.cnt_op = CNT_INC;
          resp_nxt   = ST_OK;
          state_nxt  = S_RESP;
        end
      end
      S_INS_PUT: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_ZERO;
        cmd.wr_new      = 1'b1;
        cmd.cnt_op      = CNT_INC;
        resp_nxt        = ST_OK;
        state_nxt       = S_RESP;
      end
      S_DEL_CMP: begin
        if (stat.rd_eq) begin
          if (stat.p_last) begin
            cmd.cnt_op = CNT_DEC;
            resp_nxt   = ST_OK;
            state_nxt  = S_RESP;
          end else begin
            cmd.p_op  = P_INC;
            cmd.rd_en = 1'b1;
            state_nxt = S_DEL_SHIFT;
          end
        end else if (stat.p_last) begin
          resp_nxt  = ST_NOTFOUND;
          state_nxt = S_RESP;
        end else begin
          cmd.p_op  = P_INC;
          cmd.rd_en = 1'b1;
        end
      end
      S_DEL_SHIFT: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_PREV;
        if (stat.p_last) begin
          cmd.cnt_op = CNT_DEC;
          resp_nxt   = ST_OK;
          state_nxt  = S_RESP;
        end else begin
          cmd.p_op  = P_INC;
          cmd.rd_en = 1'b1;
        end
      end
      S_RO_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_OK;
          cmd.out_entry  = 1'b1;
          cmd.out_last   = stat.p_last;
          if (stat.p_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.p_op  = P_INC;
            cmd.rd_en = 1'b1;
          end
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = resp_r;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      resp_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

endmodule

// ===== hdl/sorted_key_table.sv =====
// top level of the sorted key table
// Requests arrive on in_if (req_type, key, payload_tag) and transfer when
// valid and ready are both high; ready is high only while no request is in
// work. Results leave on out_if (status, key_out, tag_out, last) from an
// output register, with last marking the final result of a request.
// The max_key limit is written through cfg_if at any transfer; it is always
// ready and takes effect on the next insert.
// Entries live in a CAPACITY-deep memory with one read and one write port,
// and every walk visits one entry per cycle through that port pair (the
// read-out walk only while the output register can take a result):
//   insert: from the top entry down, moves each larger key up one place,
//           then writes the new entry above the first key not larger (or at 0)
//   delete: scans from index 0 for the key, then moves each later entry
//           down one place; an absent key is scanned for to the end
//   clear, rejected requests: one result; read-out: one per entry, in order
// Reset empties the table and restores max_key to 99999; memory contents
// are not cleared. While the receiver holds ready low the pending result
// stays in the output register and the walk pauses until it transfers.
module sorted_key_table #(
  parameter int CAPACITY = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  skt_in_if.sink    in_if,
  skt_out_if.source out_if,
  skt_cfg_if.sink   cfg_if
);
  import skt_pkg::*;

  skt_cmd_t  cmd;
  skt_stat_t stat;

  skt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  skt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

// ===== verif/tb.sv =====
// testbench for the sorted key table: directed and random requests against a built-in predictor
module tb;
  import skt_pkg::*;

  localparam int DEPTH = 8;
  localparam int SETTLE = DEPTH + 4;
  localparam int DRAIN_LIMIT = 40000;

  typedef struct packed {
    status_t status;
    key_t    key;
    tag_t    tag;
    logic    last;
  } result_t;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic clk;
  logic rst_n;

  skt_in_if  in_ch ();
  skt_out_if out_ch ();
  skt_cfg_if cfg_ch ();

  sorted_key_table #(.CAPACITY(DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  key_t     tbl_keys [DEPTH];
  tag_t     tbl_tags [DEPTH];
  int       tbl_count;
  key_t     lim_key;
  result_t  result_q [$];
  int       err_count;
  int       burst_left;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2000000;
    $display("sorted_key_table test failed");
    $finish;
  end

  // expected results of one request, table state updated in place
  function automatic void predict_request(req_t rq, key_t k, tag_t t);
    int pos;
    int i;
    result_t r;
    r = '0;
    r.last = 1'b1;
    case (rq)
      REQ_INSERT: begin
        if (tbl_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (k > lim_key) begin
          r.status = ST_RANGE;
        end else begin
          pos = 0;
          while (pos < tbl_count && tbl_keys[pos] <= k) pos++;
          for (i = tbl_count; i > pos; i--) begin
            tbl_keys[i] = tbl_keys[i-1];
            tbl_tags[i] = tbl_tags[i-1];
          end
          tbl_keys[pos] = k;
          tbl_tags[pos] = t;
          tbl_count++;
          r.status = ST_OK;
        end
        result_q.push_back(r);
      end
      REQ_DELETE: begin
        if (tbl_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = 0;
          while (pos < tbl_count && tbl_keys[pos] != k) pos++;
          if (pos >= tbl_count) begin
            r.status = ST_NOTFOUND;
          end else begin
            for (i = pos; i + 1 < tbl_count; i++) begin
              tbl_keys[i] = tbl_keys[i+1];
              tbl_tags[i] = tbl_tags[i+1];
            end
            tbl_count--;
            r.status = ST_OK;
          end
        end
        result_q.push_back(r);
      end
      REQ_CLEAR: begin
        tbl_count = 0;
        r.status = ST_OK;
        result_q.push_back(r);
      end
      default: begin
        if (tbl_count == 0) begin
          r.status = ST_EMPTY;
          result_q.push_back(r);
        end else begin
          for (i = 0; i < tbl_count; i++) begin
            r.status = ST_OK;
            r.key = tbl_keys[i];
            r.tag = tbl_tags[i];
            r.last = (i == tbl_count - 1);
            result_q.push_back(r);
          end
        end
      end
    endcase
  endfunction

  // one request transfer, with bursts and random gaps in between
  task automatic send_request(req_t rq, key_t k, tag_t t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.req_type <= rq;
    in_ch.key <= k;
    in_ch.payload_tag <= t;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_request(rq, k, t);
  endtask

  task automatic drain_results();
    int waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    while (result_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (result_q.size() != 0) begin
      $display("%0d expected results never arrived", result_q.size());
      err_count += result_q.size();
      result_q.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_max_key(key_t v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.max_key <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    lim_key = v;
    cfg_ch.valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (result_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: status %0d key %0d tag %h last %b",
                   out_ch.status, out_ch.key_out, out_ch.tag_out, out_ch.last);
      end else begin
        want = result_q.pop_front();
        if (out_ch.status !== want.status || out_ch.key_out !== want.key ||
            out_ch.tag_out !== want.tag || out_ch.last !== want.last) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected status %0d key %0d tag %h last %b, got %0d %0d %h %b",
                     want.status, want.key, want.tag, want.last,
                     out_ch.status, out_ch.key_out, out_ch.tag_out, out_ch.last);
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    logic go;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:  go = 1'b1;
      RX_LIGHT: go = ($urandom_range(0, 3) != 0);
      RX_HEAVY: go = ($urandom_range(0, 3) == 0);
      default:  go = ((rx_tick % 7) < 4);
    endcase
    rx_tick <= rx_tick + 1;
    out_ch.ready <= go;
  end

  task automatic test_empty_table();
    send_request(REQ_READ, key_t'($urandom), $urandom);
    send_request(REQ_DELETE, 17'd5, $urandom);
    send_request(REQ_CLEAR, key_t'($urandom), $urandom);
    drain_results();
  endtask

  // fill with duplicates and extremes, then overflow
  task automatic test_fill_order();
    send_request(REQ_INSERT, 17'd500, 32'h0000_0000);
    send_request(REQ_INSERT, 17'd3, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 17'd500, 32'hA5A5_0001);
    send_request(REQ_INSERT, 17'd0, $urandom);
    send_request(REQ_INSERT, MAX_KEY_RESET, $urandom);
    send_request(REQ_INSERT, MAX_KEY_RESET + 17'd1, $urandom);
    send_request(REQ_INSERT, 17'h1FFFF, $urandom);
    send_request(REQ_INSERT, 17'd42, $urandom);
    send_request(REQ_INSERT, 17'd500, 32'hA5A5_0002);
    send_request(REQ_INSERT, 17'd7, $urandom);
    send_request(REQ_INSERT, 17'd1, $urandom);
    send_request(REQ_INSERT, 17'h1FFFF, $urandom);
    send_request(REQ_READ, key_t'($urandom), $urandom);
    drain_results();
  endtask

  task automatic test_delete_rules();
    send_request(REQ_DELETE, 17'd12345, $urandom);
    send_request(REQ_DELETE, 17'd500, $urandom);
    send_request(REQ_DELETE, 17'd0, $urandom);
    send_request(REQ_DELETE, MAX_KEY_RESET, $urandom);
    send_request(REQ_READ, key_t'($urandom), $urandom);
    send_request(REQ_CLEAR, key_t'($urandom), $urandom);
    send_request(REQ_READ, key_t'($urandom), $urandom);
    drain_results();
  endtask

  task automatic test_key_limit();
    write_max_key('0);
    send_request(REQ_INSERT, 17'd0, $urandom);
    send_request(REQ_INSERT, 17'd1, $urandom);
    drain_results();
    write_max_key(17'h1FFFF);
    send_request(REQ_INSERT, 17'h1FFFF, $urandom);
    send_request(REQ_READ, key_t'($urandom), $urandom);
    drain_results();
  endtask

  task automatic test_random_traffic();
    key_t lim;
    key_t k;
    req_t rq;
    int r;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       lim = 17'h1FFFF;
        1:       lim = 17'd20;
        2:       lim = '0;
        3:       lim = MAX_KEY_RESET;
        default: lim = key_t'($urandom);
      endcase
      write_max_key(lim);
      for (int n = 0; n < 60; n++) begin
        r = $urandom_range(0, 99);
        if (r < 45)      rq = REQ_INSERT;
        else if (r < 70) rq = REQ_DELETE;
        else if (r < 93) rq = REQ_READ;
        else             rq = REQ_CLEAR;
        r = $urandom_range(0, 9);
        if (r < 4 && tbl_count > 0)
          k = tbl_keys[$urandom_range(0, tbl_count - 1)];
        else if (r < 7)
          k = key_t'($urandom_range(0, 15));
        else if (r < 8)
          k = lim_key + key_t'($urandom_range(0, 1));
        else
          k = key_t'($urandom);
        send_request(rq, k, $urandom);
      end
      drain_results();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= REQ_INSERT;
    in_ch.key <= '0;
    in_ch.payload_tag <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.max_key <= MAX_KEY_RESET;
    err_count = 0;
    burst_left = 0;
    tbl_count = 0;
    lim_key = MAX_KEY_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_fill_order();
    test_delete_rules();
    test_key_limit();
    test_random_traffic();
    drain_results();
    if (err_count == 0) begin
      $display("sorted_key_table test passed");
    end else begin
      $display("sorted_key_table test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/skt_pkg.sv
hdl/skt_ifs.sv
hdl/skt_dp.sv
hdl/skt_ctrl.sv
hdl/sorted_key_table.sv
verif/tb.sv
